/* rtl/core/assert_macros.svh */
// assertion macros for the rtl files, included by edm_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* rtl/core/edm_pkg.sv */
// shared types and constants of the distance matrix block
`default_nettype none
package edm_pkg;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // input item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_ROW   = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_ROW
    } t_op;

    typedef enum logic {
        BK_IDLE,
        BK_ROW
    } t_back_state;

    // head of the job queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_job_hdr;
endpackage
`default_nettype wire

/* rtl/core/edm_ram.sv */
// generic single write port ram with registered read
`default_nettype none
module edm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/edm_front.sv */
// front end: takes items, drops unused kinds, queues jobs in order
`default_nettype none
module edm_front #(
    parameter int COORD_BITS = 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic [1:0]            i_kind,
    input  wire logic [COORD_BITS-1:0] i_coord_x,
    input  wire logic [COORD_BITS-1:0] i_coord_y,
    output edm_pkg::t_job_hdr          o_hdr,
    output logic      [COORD_BITS-1:0] o_x,
    output logic      [COORD_BITS-1:0] o_y,
    input  wire logic                  i_pop
);
    localparam int QD = 2;

    edm_pkg::t_op          r_q_op [QD];
    logic [COORD_BITS-1:0] r_q_x  [QD];
    logic [COORD_BITS-1:0] r_q_y  [QD];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic [1:0]            n_cnt;
    logic                  acc, push;
    edm_pkg::t_op          op;

    assign o_busy = (r_cnt == 2'(QD));
    assign acc    = i_start && !o_busy;

    // classify the item kind
    always_comb begin
        op   = edm_pkg::OP_CLEAR;
        push = 1'b0;
        unique case (i_kind)
            edm_pkg::KIND_CLEAR: begin op = edm_pkg::OP_CLEAR; push = acc; end
            edm_pkg::KIND_LOAD:  begin op = edm_pkg::OP_LOAD;  push = acc; end
            edm_pkg::KIND_ROW:   begin op = edm_pkg::OP_ROW;   push = acc; end
            default:             begin op = edm_pkg::OP_CLEAR; push = 1'b0; end
        endcase
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_op[r_wp] <= op;
            r_q_x[r_wp]  <= i_coord_x;
            r_q_y[r_wp]  <= i_coord_y;
        end
    end

    // queue occupancy
    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push)  r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    // queue head
    assign o_hdr.valid = (r_cnt != 2'd0);
    assign o_hdr.op    = r_q_op[r_rp];
    assign o_x         = r_q_x[r_rp];
    assign o_y         = r_q_y[r_rp];
endmodule
`default_nettype wire

/* rtl/core/edm_sqrt_pipe.sv */
// pipelined digit-by-digit square root, one root bit per stage
`default_nettype none
module edm_sqrt_pipe #(
    parameter int DIST_W    = 18,
    parameter int FRAC_BITS = 8,
    parameter int TAG_W     = 7,
    localparam int SQ_W     = 2 * (DIST_W - FRAC_BITS),
    localparam int REM_W    = DIST_W + 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [SQ_W-1:0]   i_sq,
    input  wire logic [TAG_W-1:0]  i_tag,
    output logic                   o_valid,
    output logic      [DIST_W-1:0] o_root,
    output logic      [TAG_W-1:0]  o_tag
);
    logic              s_valid [DIST_W+1];
    logic [SQ_W-1:0]   s_sq    [DIST_W+1];
    logic [TAG_W-1:0]  s_tag   [DIST_W+1];
    logic [REM_W-1:0]  s_rem   [DIST_W+1];
    logic [DIST_W-1:0] s_root  [DIST_W+1];

    assign s_valid[0] = i_valid;
    assign s_sq[0]    = i_sq;
    assign s_tag[0]   = i_tag;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;

    for (genvar k = 0; k < DIST_W; k++) begin : g_stage
        localparam int I = DIST_W - 1 - k;
        logic              r_valid;
        logic [SQ_W-1:0]   r_sq;
        logic [TAG_W-1:0]  r_tag;
        logic [REM_W-1:0]  r_rem;
        logic [DIST_W-1:0] r_root;
        logic [1:0]        pair;
        logic [REM_W-1:0]  rem_sh, trial;

        // next pair of radicand bits, zeros in the fraction part
        if (I >= FRAC_BITS) begin : g_pair
            assign pair = s_sq[k][2*(I-FRAC_BITS)+1 -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {s_rem[k][REM_W-3:0], pair};
        assign trial  = {s_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= s_valid[k];
            end
        end

        // trial subtract decides one root bit
        always_ff @(posedge i_clk) begin
            r_sq  <= s_sq[k];
            r_tag <= s_tag[k];
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {s_root[k][DIST_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {s_root[k][DIST_W-2:0], 1'b0};
            end
        end

        assign s_valid[k+1] = r_valid;
        assign s_sq[k+1]    = r_sq;
        assign s_tag[k+1]   = r_tag;
        assign s_rem[k+1]   = r_rem;
        assign s_root[k+1]  = r_root;
    end

    assign o_valid = s_valid[DIST_W];
    assign o_root  = s_root[DIST_W];
    assign o_tag   = s_tag[DIST_W];
endmodule
`default_nettype wire

/* rtl/core/edm_back.sv */
// back end: task store, row sequencer, difference, square and square root stages
`default_nettype none
`include "assert_macros.svh"
module edm_back #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 9,
    parameter int FRAC_BITS  = 8,
    localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int DIST_W    = COORD_BITS + 1 + FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [edm_pkg::CFG_W-1:0] i_points_in_use,
    input  wire edm_pkg::t_job_hdr     i_hdr,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic      [IDX_W-1:0]      o_index,
    output logic      [DIST_W-1:0]     o_dist,
    output logic                       o_last
);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int LIM_W  = (CNT_W > edm_pkg::CFG_W) ? CNT_W : edm_pkg::CFG_W;
    localparam int SQ_W   = 2 * COORD_BITS + 2;
    localparam int TAG_W  = IDX_W + 1;

    edm_pkg::t_back_state  r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_j, n_j, r_last, n_last;
    logic [COORD_BITS-1:0] r_px, r_py, n_px, n_py;
    logic                  we, issue, room;

    // read issue stage
    logic                  r_s0_valid, r_s0_last;
    logic [IDX_W-1:0]      r_s0_idx;
    logic [COORD_BITS-1:0] r_s0_px, r_s0_py;
    // difference stage
    logic                  r_s1_valid, r_s1_last;
    logic [IDX_W-1:0]      r_s1_idx;
    logic [COORD_BITS-1:0] r_s1_dx, r_s1_dy;
    // square stage
    logic                  r_s2_valid, r_s2_last;
    logic [IDX_W-1:0]      r_s2_idx;
    logic [SQ_W-1:0]       r_s2_sq;

    logic [2*COORD_BITS-1:0] rdata;
    logic [COORD_BITS-1:0]   tx, ty;
    logic [TAG_W-1:0]        out_tag;

    // store accepts a load while below both the configured limit and MAX_POINTS
    assign room = (LIM_W'(r_count) < LIM_W'(i_points_in_use))
               && (r_count != CNT_W'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edm_pkg::BK_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_last <= n_last;
        r_px   <= n_px;
        r_py   <= n_py;
    end

    // job sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_j     = r_j;
        n_last  = r_last;
        n_px    = r_px;
        n_py    = r_py;
        o_pop   = 1'b0;
        we      = 1'b0;
        issue   = 1'b0;
        unique case (r_state)
            edm_pkg::BK_IDLE: begin
                if (i_hdr.valid) begin
                    o_pop = 1'b1;
                    unique case (i_hdr.op)
                        edm_pkg::OP_CLEAR: n_count = '0;
                        edm_pkg::OP_LOAD: begin
                            if (room) begin
                                we      = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        edm_pkg::OP_ROW: begin
                            if (r_count != '0) begin
                                n_state = edm_pkg::BK_ROW;
                                n_j     = '0;
                                n_last  = IDX_W'(r_count - CNT_W'(1));
                                n_px    = i_x;
                                n_py    = i_y;
                            end
                        end
                        default: n_count = r_count;
                    endcase
                end
            end
            edm_pkg::BK_ROW: begin
                issue = 1'b1;
                n_j   = r_j + IDX_W'(1);
                if (r_j == r_last) begin
                    n_state = edm_pkg::BK_IDLE;
                end
            end
            default: n_state = edm_pkg::BK_IDLE;
        endcase
    end

    edm_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (IDX_W'(r_count)),
        .i_wdata ({i_x, i_y}),
        .i_raddr (r_j),
        .o_rdata (rdata)
    );

    assign tx = rdata[2*COORD_BITS-1:COORD_BITS];
    assign ty = rdata[COORD_BITS-1:0];

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s0_valid <= issue;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // tag, absolute differences, sum of squares
    always_ff @(posedge i_clk) begin
        r_s0_idx  <= r_j;
        r_s0_last <= (r_j == r_last);
        r_s0_px   <= r_px;
        r_s0_py   <= r_py;
        r_s1_idx  <= r_s0_idx;
        r_s1_last <= r_s0_last;
        r_s1_dx   <= (r_s0_px >= tx) ? r_s0_px - tx : tx - r_s0_px;
        r_s1_dy   <= (r_s0_py >= ty) ? r_s0_py - ty : ty - r_s0_py;
        r_s2_idx  <= r_s1_idx;
        r_s2_last <= r_s1_last;
        r_s2_sq   <= SQ_W'(r_s1_dx * r_s1_dx) + SQ_W'(r_s1_dy * r_s1_dy);
    end

    edm_sqrt_pipe #(
        .DIST_W    (DIST_W),
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (TAG_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_sq    (r_s2_sq),
        .i_tag   ({r_s2_idx, r_s2_last}),
        .o_valid (o_valid),
        .o_root  (o_dist),
        .o_tag   (out_tag)
    );

    assign o_index = out_tag[TAG_W-1:1];
    assign o_last  = out_tag[0];

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(MAX_POINTS))
    `ASSERT_PROP(a_row_walk, i_clk, i_rst_n, (r_state == edm_pkg::BK_ROW) |-> (r_j <= r_last))
    `ASSERT_NEVER(a_no_pop_in_row, i_clk, i_rst_n, o_pop && (r_state == edm_pkg::BK_ROW))
endmodule
`default_nettype wire

/* rtl/core/euclidean_distance_matrix.sv */
// top level of the robot-to-task euclidean distance matrix block
//
//  port group    direction  handshake            payload
//  command       in         start / busy         i_kind, i_coord_x, i_coord_y
//  result        out        o_strobe, one cycle  o_task_index, o_distance_q8, o_last_in_row
//  config        in         i_cfg_valid/o_cfg_ready  i_cfg_data (points_in_use)
//
// clear and load items retire in the cycle they reach the queue head of an idle back end
// a row item holds the back end in the row state while it reads each stored task; its results
// come one per cycle through the read, difference, square and square root stages
// busy rises only when the two-entry job queue is full
// synchronous active-low reset empties the store count and sets points_in_use to 64
`default_nettype none
module euclidean_distance_matrix #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 9,
    parameter int FRAC_BITS  = 8,
    localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int DIST_W    = COORD_BITS + 1 + FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [COORD_BITS-1:0]         i_coord_x,
    input  wire logic [COORD_BITS-1:0]         i_coord_y,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [edm_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_strobe,
    output logic      [IDX_W-1:0]              o_task_index,
    output logic      [DIST_W-1:0]             o_distance_q8,
    output logic                               o_last_in_row
);
    logic [edm_pkg::CFG_W-1:0] r_points_in_use;
    edm_pkg::t_job_hdr         hdr;
    logic [COORD_BITS-1:0]     q_x, q_y;
    logic                      pop;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use <= edm_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_points_in_use <= i_cfg_data;
        end
    end

    edm_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_kind    (i_kind),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .o_hdr     (hdr),
        .o_x       (q_x),
        .o_y       (q_y),
        .i_pop     (pop)
    );

    edm_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_points_in_use (r_points_in_use),
        .i_hdr           (hdr),
        .i_x             (q_x),
        .i_y             (q_y),
        .o_pop           (pop),
        .o_valid         (o_strobe),
        .o_index         (o_task_index),
        .o_dist          (o_distance_q8),
        .o_last          (o_last_in_row)
    );
endmodule
`default_nettype wire
